// ===== rtl/qgi_pkg.sv =====
`timescale 1ns / 1ps

package qgi_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = 16;
  localparam int COORD_W     = FRAC_BITS + 2;
  localparam int DIM_W       = 9;
  localparam int ADDR_W      = 16;
  localparam int STATUS_W    = 2;
  localparam int REG_IDX_W   = 2;

  // scaled sample: SAMPLE_BITS integer bits, FRAC_BITS fraction bits
  localparam int SCALED_W = SAMPLE_BITS + FRAC_BITS;
  // coord * (dim-1)
  localparam int POS_W    = COORD_W + DIM_W + 1;

  localparam logic signed [SCALED_W-1:0] SAT_HI =
    {1'b0, {(SAMPLE_BITS-1){1'b1}}, {FRAC_BITS{1'b0}}};
  localparam logic signed [SCALED_W-1:0] SAT_LO =
    {1'b1, {(SAMPLE_BITS-1){1'b0}}, {FRAC_BITS{1'b0}}};

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_EVAL     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_WRITE    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_ADDR = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_TOO_BIG  = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_DIM_X = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DIM_Y = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DIM_Z = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_DIM_W = 2'd3;

endpackage

// ===== rtl/qgi_blend.sv =====
`timescale 1ns / 1ps

module qgi_blend (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [qgi_pkg::SCALED_W-1:0]  a,
  input  logic signed [qgi_pkg::SCALED_W-1:0]  b,
  input  logic signed [qgi_pkg::POS_W-1:0]     t,
  output logic                                 done,
  output logic signed [qgi_pkg::SCALED_W-1:0]  r
);
  import qgi_pkg::*;

  localparam int D_W    = SCALED_W + 1;
  localparam int LO_W   = D_W / 2;
  localparam int HI_W   = D_W - LO_W;
  localparam int PLO_W  = LO_W + 1 + POS_W;
  localparam int PHI_W  = HI_W + POS_W;
  localparam int PROD_W = D_W + POS_W + 1;
  localparam int SUM_W  = PROD_W - FRAC_BITS + 1;

  logic [3:0]                stage;
  logic signed [D_W-1:0]     d;
  logic signed [SCALED_W-1:0] a_q;
  logic signed [POS_W-1:0]   t_q;
  logic signed [PLO_W-1:0]   p_lo;
  logic signed [PHI_W-1:0]   p_hi;
  logic signed [PROD_W-1:0]  prod;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SCALED_W-1:0] sum_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
    end else begin
      stage <= {stage[2:0], start};
    end
  end

  always_comb begin
    sum = SUM_W'(a_q) + SUM_W'(prod >>> FRAC_BITS);
    if (sum > SUM_W'(SAT_HI)) begin
      sum_sat = SAT_HI;
    end else if (sum < SUM_W'(SAT_LO)) begin
      sum_sat = SAT_LO;
    end else begin
      sum_sat = sum[SCALED_W-1:0];
    end
  end

  // d * t split into two narrow products, summed and rescaled
  always_ff @(posedge clk) begin
    if (start) begin
      d   <= D_W'(b) - D_W'(a);
      a_q <= a;
      t_q <= t;
    end
    if (stage[0]) begin
      p_lo <= $signed({1'b0, d[LO_W-1:0]}) * t_q;
      p_hi <= $signed(d[D_W-1:LO_W]) * t_q;
    end
    if (stage[1]) begin
      prod <= (PROD_W'(p_hi) <<< LO_W) + PROD_W'(p_lo);
    end
    if (stage[2]) begin
      r <= sum_sat;
    end
  end

  assign done = stage[3];

`ifndef ASSERT_OFF
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst) $onehot0(stage))
    else $error("blend unit holds more than one request");
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> stage == '0)
    else $error("blend started while busy");
  a_done_latency: assert property (@(posedge clk) disable iff (rst) start |-> ##4 done)
    else $error("blend result not ready four cycles after start");
`endif

endmodule

// ===== rtl/quadrilinear_grid_interpolator.sv =====
`timescale 1ns / 1ps

// Quadrilinear interpolator over a 4-D sample grid held in one on-chip memory.
// Request channel (item_valid / item_stall): func 0 writes write_value at
// write_address; func 1 evaluates the grid at coord_x..coord_w (signed Q2.16,
// 0..1 spans each axis). Result channel (result_valid / result_stall): one
// result per request with result_value, status and batch_done.
// Grid dimensions come from the cfg_write / cfg_index / cfg_data port; write
// them only while no request is in progress.
// A write's result appears in the cycle after it is accepted. An evaluation
// runs setup (S_SETUP, S_SIZE, S_ADDR), then per corner one grid read (S_READ,
// S_LOAD, S_PUSH) and per blend a pass through the shared blend unit (two split
// multiplies, sum, rescale), 16 corners and 15 blends, then rounding. A grid
// that is too large answers straight after setup, without a grid read.
// One request is worked on at a time; a new one is taken while the previous
// result waits in the output register, as long as that register can take the
// next result. A stalled result holds; a write is held off until the output
// register frees, an evaluation waits at its end.
// Reset clears the dimensions to 1 and the control state; grid contents are
// undefined until written.
module quadrilinear_grid_interpolator #(
  parameter int GRID_DEPTH = 65536,
  parameter int MAX_DIM    = 256
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_write,
  input  logic [qgi_pkg::REG_IDX_W-1:0]            cfg_index,
  input  logic [qgi_pkg::DIM_W-1:0]                cfg_data,
  input  logic                                     item_valid,
  output logic                                     item_stall,
  input  logic                                     func,
  input  logic [qgi_pkg::ADDR_W-1:0]               write_address,
  input  logic signed [qgi_pkg::SAMPLE_BITS-1:0]   write_value,
  input  logic signed [qgi_pkg::COORD_W-1:0]       coord_x,
  input  logic signed [qgi_pkg::COORD_W-1:0]       coord_y,
  input  logic signed [qgi_pkg::COORD_W-1:0]       coord_z,
  input  logic signed [qgi_pkg::COORD_W-1:0]       coord_w,
  input  logic                                     batch_last,
  output logic                                     result_valid,
  input  logic                                     result_stall,
  output logic signed [qgi_pkg::SAMPLE_BITS-1:0]   result_value,
  output logic [qgi_pkg::STATUS_W-1:0]             status,
  output logic                                     batch_done
);
  import qgi_pkg::*;

  localparam int AW     = $clog2(GRID_DEPTH);
  localparam int WIDE_A = 21;
  localparam int PROD_W = 4 * DIM_W;
  localparam logic [WIDE_A-1:0] DEPTH_A = WIDE_A'(GRID_DEPTH);
  localparam logic [PROD_W-1:0] DEPTH_P = PROD_W'(GRID_DEPTH);
  localparam logic [12:0]       MAXD    = 13'(MAX_DIM);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SETUP = 10'b0000000010,
    S_SIZE  = 10'b0000000100,
    S_ADDR  = 10'b0000001000,
    S_READ  = 10'b0000010000,
    S_LOAD  = 10'b0000100000,
    S_PUSH  = 10'b0001000000,
    S_BLEND = 10'b0010000000,
    S_ROUND = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state, state_next;

  logic [DIM_W-1:0] dim [4];
  logic [DIM_W-1:0] effd [4];
  logic [DIM_W-1:0] dm1 [4];

  logic signed [COORD_W-1:0] coord_q [4];
  logic signed [POS_W-1:0]   pos [4];
  logic signed [POS_W-1:0]   t_q [4];
  logic [DIM_W-1:0]          lo [4];
  logic [DIM_W-1:0]          hi [4];
  logic [AW-1:0]             term [4][2];

  logic [2*DIM_W-1:0] p01, p23;
  logic [PROD_W-1:0]  prod;
  logic [AW-1:0]      sw;
  logic [AW-1:0]      sz;
  logic               tl_dim;

  logic [SAMPLE_BITS-1:0] mem [GRID_DEPTH];
  logic [SAMPLE_BITS-1:0] mem_q;
  logic                   mem_we;
  logic [AW-1:0]          mem_wa;
  logic [AW-1:0]          mem_ra;

  logic [3:0]                  k;
  logic [2:0]                  lvl;
  logic signed [SCALED_W-1:0]  carry;
  logic signed [SCALED_W-1:0]  pend [4];
  logic [3:0]                  pend_v;
  logic signed [SCALED_W-1:0]  carry_rnd;

  logic                        blend_start;
  logic                        blend_done;
  logic signed [SCALED_W-1:0]  blend_r;

  logic signed [SAMPLE_BITS-1:0] res_value;
  logic [STATUS_W-1:0]           res_status;
  logic                          res_batch;

  logic              accept;
  logic              out_free;
  logic              load_out;
  logic [WIDE_A-1:0] waddr_wide;
  logic              addr_ok;
  logic              too_big;

  assign out_free   = !result_valid || !result_stall;
  assign item_stall = (state != S_IDLE) || !out_free;
  assign accept     = item_valid && !item_stall;
  assign waddr_wide = WIDE_A'(write_address);
  assign addr_ok    = waddr_wide < DEPTH_A;
  assign too_big    = tl_dim || (prod > DEPTH_P);
  assign sz         = AW'(p01);
  assign carry_rnd  = carry + SCALED_W'(1 << (FRAC_BITS - 1));

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      effd[i] = (dim[i] == '0) ? DIM_W'(1) : dim[i];
      dm1[i]  = effd[i] - DIM_W'(1);
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        dim[i] <= DIM_W'(1);
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DIM_X: dim[0] <= cfg_data;
        REG_DIM_Y: dim[1] <= cfg_data;
        REG_DIM_Z: dim[2] <= cfg_data;
        REG_DIM_W: dim[3] <= cfg_data;
        default:   dim[0] <= dim[0];
      endcase
    end
  end

  // grid memory
  assign mem_we = accept && (func == FUNC_WRITE) && addr_ok;
  assign mem_wa = waddr_wide[AW-1:0];
  assign mem_ra = term[0][k[0]] + term[1][k[1]] + term[2][k[2]] + term[3][k[3]];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= write_value;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      mem_q <= mem[mem_ra];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept && func == FUNC_EVAL) state_next = S_SETUP;
      S_SETUP: state_next = S_SIZE;
      S_SIZE:  state_next = S_ADDR;
      S_ADDR:  state_next = too_big ? S_DONE : S_READ;
      S_READ:  state_next = S_LOAD;
      S_LOAD:  state_next = S_PUSH;
      S_PUSH: begin
        if (lvl == 3'd4) begin
          state_next = S_ROUND;
        end else if (pend_v[lvl[1:0]]) begin
          state_next = S_BLEND;
        end else begin
          state_next = S_READ;
        end
      end
      S_BLEND: if (blend_done) state_next = S_PUSH;
      S_ROUND: state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign blend_start = (state == S_PUSH) && (lvl != 3'd4) && pend_v[lvl[1:0]];

  qgi_blend u_blend (
    .clk   (clk),
    .rst   (rst),
    .start (blend_start),
    .a     (pend[lvl[1:0]]),
    .b     (carry),
    .t     (t_q[lvl[1:0]]),
    .done  (blend_done),
    .r     (blend_r)
  );

  // query datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= '0;
      k      <= '0;
      lvl    <= '0;
    end else begin
      unique case (state)
        S_ADDR: begin
          pend_v <= '0;
          k      <= '0;
        end
        S_LOAD: lvl <= '0;
        S_PUSH: begin
          if (lvl != 3'd4) begin
            if (pend_v[lvl[1:0]]) begin
              pend_v[lvl[1:0]] <= 1'b0;
            end else begin
              pend_v[lvl[1:0]] <= 1'b1;
              k <= k + 4'd1;
            end
          end
        end
        S_BLEND: if (blend_done) lvl <= lvl + 3'd1;
        default: lvl <= lvl;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      coord_q[0] <= coord_x;
      coord_q[1] <= coord_y;
      coord_q[2] <= coord_z;
      coord_q[3] <= coord_w;
      res_batch  <= batch_last;
    end
    unique case (state)
      S_SETUP: begin
        for (int i = 0; i < 4; i++) begin
          pos[i] <= coord_q[i] * $signed({1'b0, dm1[i]});
        end
        p01    <= effd[0] * effd[1];
        p23    <= effd[2] * effd[3];
        tl_dim <= ({4'b0, effd[0]} > MAXD) || ({4'b0, effd[1]} > MAXD) ||
                  ({4'b0, effd[2]} > MAXD) || ({4'b0, effd[3]} > MAXD);
      end
      S_SIZE: begin
        for (int i = 0; i < 4; i++) begin
          logic [DIM_W-1:0] ti;
          logic [POS_W-FRAC_BITS-1:0] ip;
          ip = pos[i][POS_W-1:FRAC_BITS];
          if (pos[i][POS_W-1]) begin
            ti = '0;
          end else if (ip > (POS_W-FRAC_BITS)'(dm1[i])) begin
            ti = dm1[i];
          end else begin
            ti = ip[DIM_W-1:0];
          end
          lo[i]  <= ti;
          hi[i]  <= (ti == dm1[i]) ? dm1[i] : ti + DIM_W'(1);
          t_q[i] <= pos[i] - POS_W'({ti, {FRAC_BITS{1'b0}}});
        end
        prod <= p01 * p23;
        sw   <= AW'(p01 * effd[2]);
      end
      S_ADDR: begin
        term[0][0] <= AW'(lo[0]);
        term[0][1] <= AW'(hi[0]);
        term[1][0] <= AW'(lo[1]) * AW'(effd[0]);
        term[1][1] <= AW'(hi[1]) * AW'(effd[0]);
        term[2][0] <= AW'(lo[2] * sz);
        term[2][1] <= AW'(hi[2] * sz);
        term[3][0] <= AW'(lo[3] * sw);
        term[3][1] <= AW'(hi[3] * sw);
        res_value  <= '0;
        res_status <= STAT_TOO_BIG;
      end
      S_LOAD:  carry <= {mem_q, {FRAC_BITS{1'b0}}};
      S_PUSH: begin
        if (lvl != 3'd4 && !pend_v[lvl[1:0]]) begin
          pend[lvl[1:0]] <= carry;
        end
      end
      S_BLEND: if (blend_done) carry <= blend_r;
      S_ROUND: begin
        res_value  <= carry_rnd[SCALED_W-1:FRAC_BITS];
        res_status <= STAT_EVAL;
      end
      default: res_status <= res_status;
    endcase
  end

  // result register
  assign load_out = (accept && func == FUNC_WRITE) || (state == S_DONE && out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (state == S_DONE) begin
        result_value <= res_value;
        status       <= res_status;
        batch_done   <= res_batch;
      end else begin
        result_value <= '0;
        status       <= addr_ok ? STAT_WRITE : STAT_BAD_ADDR;
        batch_done   <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_write_answers: assert property (@(posedge clk) disable iff (rst)
      (accept && func == FUNC_WRITE) |=> result_valid)
    else $error("write request produced no result");
  a_stack_empty: assert property (@(posedge clk) disable iff (rst)
      (state == S_ROUND) |-> (pend_v == '0))
    else $error("partial blends left at end of evaluation");
  a_blend_owner: assert property (@(posedge clk) disable iff (rst)
      blend_done |-> (state == S_BLEND))
    else $error("blend result arrived outside blend wait");
`endif

endmodule
